>>> design/nns_pkg.sv
// Shared types and constants for the nearest neighbor search unit.
package nns_pkg;

  // Payload widths
  localparam int FEAT_W    = 8;
  localparam int SQ_W      = 16;
  localparam int DIST_W    = 18;
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 8;

  // Operation codes carried in func
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // One stored point: feature a in the low byte, d in the high byte
  typedef struct packed {
    logic [FEAT_W-1:0] d;
    logic [FEAT_W-1:0] c;
    logic [FEAT_W-1:0] b;
    logic [FEAT_W-1:0] a;
  } point_t;

  // Tag that follows a table read through the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } scan_tag_t;

endpackage

>>> design/nns_in_if.sv
// Input channel: valid/ready handshake carrying one request word.
interface nns_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [nns_pkg::FEAT_W-1:0] feature_a;
  logic [nns_pkg::FEAT_W-1:0] feature_b;
  logic [nns_pkg::FEAT_W-1:0] feature_c;
  logic [nns_pkg::FEAT_W-1:0] feature_d;

  modport source (output valid, func, feature_a, feature_b, feature_c, feature_d,
                  input ready);
  modport sink (input valid, func, feature_a, feature_b, feature_c, feature_d,
                output ready);
endinterface

>>> design/nns_out_if.sv
// Result channel: valid/ready handshake carrying one result word.
interface nns_out_if;
  logic                          valid;
  logic                          ready;
  logic [nns_pkg::STATUS_W-1:0]  status;
  logic [nns_pkg::OUT_IDX_W-1:0] nearest_index;
  logic [nns_pkg::DIST_W-1:0]    best_distance;

  modport source (output valid, status, nearest_index, best_distance, input ready);
  modport sink (input valid, status, nearest_index, best_distance, output ready);
endinterface

>>> design/nns_table.sv
// Point table: single-port-write, single-port-read synchronous memory.
module nns_table #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  nns_pkg::point_t     wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output nns_pkg::point_t     rd_data
);

  nns_pkg::point_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/nns_dist.sv
// Two-stage squared Euclidean distance pipeline.
module nns_dist #(
  parameter int IDX_W = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nns_pkg::scan_tag_t           in_tag,
  input  logic [IDX_W-1:0]             in_idx,
  input  nns_pkg::point_t              query,
  input  nns_pkg::point_t              entry,
  output nns_pkg::scan_tag_t           out_tag,
  output logic [IDX_W-1:0]             out_idx,
  output logic [nns_pkg::DIST_W-1:0]   out_dist
);

  localparam int FW = nns_pkg::FEAT_W;
  localparam int SW = nns_pkg::SQ_W;
  localparam int DW = nns_pkg::DIST_W;

  logic [FW-1:0] diff_a, diff_b, diff_c, diff_d;
  logic [SW-1:0] sq_a_r, sq_b_r, sq_c_r, sq_d_r;
  logic [SW-1:0] sq_a_nxt, sq_b_nxt, sq_c_nxt, sq_d_nxt;
  nns_pkg::scan_tag_t tag1_r, tag2_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r;
  logic [DW-1:0]      dist_r, dist_nxt;

  // stage 1: absolute differences and squares
  always_comb begin
    diff_a   = (query.a >= entry.a) ? (query.a - entry.a) : (entry.a - query.a);
    diff_b   = (query.b >= entry.b) ? (query.b - entry.b) : (entry.b - query.b);
    diff_c   = (query.c >= entry.c) ? (query.c - entry.c) : (entry.c - query.c);
    diff_d   = (query.d >= entry.d) ? (query.d - entry.d) : (entry.d - query.d);
    sq_a_nxt = SW'(diff_a) * SW'(diff_a);
    sq_b_nxt = SW'(diff_b) * SW'(diff_b);
    sq_c_nxt = SW'(diff_c) * SW'(diff_c);
    sq_d_nxt = SW'(diff_d) * SW'(diff_d);
  end

  // stage 2: sum of the four squares
  assign dist_nxt = DW'(sq_a_r) + DW'(sq_b_r) + DW'(sq_c_r) + DW'(sq_d_r);

  // tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    sq_a_r <= sq_a_nxt;
    sq_b_r <= sq_b_nxt;
    sq_c_r <= sq_c_nxt;
    sq_d_r <= sq_d_nxt;
    idx1_r <= in_idx;
    idx2_r <= idx1_r;
    dist_r <= dist_nxt;
  end

  assign out_tag  = tag2_r;
  assign out_idx  = idx2_r;
  assign out_dist = dist_r;

endmodule

>>> design/nearest_neighbor_search_unit.sv
// Nearest neighbor search unit: point table, scan control and result register.
//
// Usage: words arrive on in_ch (valid/ready). func = append writes the four
// features at the next free table index and returns that index with status ok,
// or status full when all TABLE_DEPTH entries are taken. func = query scans the
// stored entries and returns the lowest index with the least sum of squared
// feature differences, plus that sum; on an empty table it returns status empty.
// Results leave on out_ch (valid/ready), one per accepted word, in order.
// An append or an empty query is decoded, and its result is then registered
// into the output register. A query on N stored entries goes through a decode
// step, N table reads (one entry per cycle on the single read port), the read
// register and the two-stage distance pipeline, and then a result step.
// One word is processed at a time; in_ch.ready is high only while idle, so a
// new word is not taken until the block is through with the last one.
// Reset empties the table (entry count to zero) and drops any pending result.
// If out_ch stalls, the finished result waits in the output register and the
// block holds the next result in its control state until the register frees;
// a new word can be accepted while the old result still waits.
module nearest_neighbor_search_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  nns_in_if.sink    in_ch,
  nns_out_if.source out_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int DW    = nns_pkg::DIST_W;
  localparam int OW    = nns_pkg::OUT_IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic                          func_r;
  nns_pkg::point_t               query_r, query_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              rd_idx_r, rd_idx_nxt;
  nns_pkg::scan_tag_t            issue_tag_r, issue_tag_nxt;
  logic [IDX_W-1:0]              issue_idx_r;
  logic                          first_r, first_nxt;
  logic [IDX_W-1:0]              best_idx_r, best_idx_nxt;
  logic [DW-1:0]                 best_dist_r, best_dist_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [nns_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [OW-1:0]                 out_index_r, out_index_nxt;
  logic [DW-1:0]                 out_dist_r, out_dist_nxt;

  logic                          in_fire, out_free, table_full, rd_last;
  logic                          wr_en, rd_en;
  logic [CNT_W-1:0]              count_m1;
  logic [IDX_W+OW-1:0]           best_idx_ext, wr_idx_ext;
  nns_pkg::point_t               rd_data;
  nns_pkg::scan_tag_t            dist_tag;
  logic [IDX_W-1:0]              dist_idx;
  logic [DW-1:0]                 dist_val;

  // point table
  nns_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (query_r),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // distance pipeline
  nns_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (issue_tag_r),
    .in_idx   (issue_idx_r),
    .query    (query_r),
    .entry    (rd_data),
    .out_tag  (dist_tag),
    .out_idx  (dist_idx),
    .out_dist (dist_val)
  );

  // handshake and helpers
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign table_full   = (count_r == CNT_W'(TABLE_DEPTH));
  assign count_m1     = count_r - 1'b1;
  assign rd_last      = (rd_idx_r == count_m1[IDX_W-1:0]);
  assign best_idx_ext = {{OW{1'b0}}, best_idx_r};
  assign wr_idx_ext   = {{OW{1'b0}}, count_r[IDX_W-1:0]};
  assign wr_en = (state_r == S_EXEC) && (func_r == nns_pkg::FUNC_APPEND) &&
                 out_free && !table_full;
  assign rd_en = (state_r == S_SCAN);

  // control and result selection
  always_comb begin
    state_nxt      = state_r;
    query_nxt      = query_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    first_nxt      = first_r;
    best_idx_nxt   = best_idx_r;
    best_dist_nxt  = best_dist_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_dist_nxt   = out_dist_r;
    issue_tag_nxt  = '0;

    // fold each pipeline distance into the running best; strict less keeps lowest index
    if (dist_tag.valid && (first_r || (dist_val < best_dist_r))) begin
      best_idx_nxt  = dist_idx;
      best_dist_nxt = dist_val;
      first_nxt     = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          query_nxt = '{d: in_ch.feature_d, c: in_ch.feature_c,
                        b: in_ch.feature_b, a: in_ch.feature_a};
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func_r == nns_pkg::FUNC_APPEND) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_dist_nxt  = '0;
            if (table_full) begin
              out_status_nxt = nns_pkg::STAT_FULL;
              out_index_nxt  = '0;
            end else begin
              out_status_nxt = nns_pkg::STAT_OK;
              out_index_nxt  = wr_idx_ext[OW-1:0];
              count_nxt      = count_r + 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end else if (count_r == '0) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = nns_pkg::STAT_EMPTY;
            out_index_nxt  = '0;
            out_dist_nxt   = '0;
            state_nxt      = S_IDLE;
          end
        end else begin
          rd_idx_nxt = '0;
          first_nxt  = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        // one table read per cycle
        issue_tag_nxt = '{valid: 1'b1, last: rd_last};
        rd_idx_nxt    = rd_idx_r + 1'b1;
        if (rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (dist_tag.valid && dist_tag.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = nns_pkg::STAT_OK;
          out_index_nxt  = best_idx_ext[OW-1:0];
          out_dist_nxt   = best_dist_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_tag_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_tag_r <= issue_tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_ch.func;
    end
    query_r      <= query_nxt;
    rd_idx_r     <= rd_idx_nxt;
    issue_idx_r  <= rd_idx_r;
    first_r      <= first_nxt;
    best_idx_r   <= best_idx_nxt;
    best_dist_r  <= best_dist_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  // result word
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.nearest_index = out_index_r;
  assign out_ch.best_distance = out_dist_r;

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // distance pipeline output only while a scan is in flight
  a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dist_tag.valid |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("distance word outside scan");

  // a table-full status is reported only when the table is full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_status_r == nns_pkg::STAT_FULL) |->
      (count_r == CNT_W'(TABLE_DEPTH)))
    else $error("full status with free entries");

  // the table is never written during a scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_DRAIN) |-> !wr_en)
    else $error("table write during scan");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nearest neighbor search unit: appends, queries, ties, full table.
module testbench;

  localparam int TABLE_DEPTH = 256;
  localparam int IDLE_PCT    = 13;

  // One predicted result word
  typedef struct packed {
    logic [nns_pkg::STATUS_W-1:0]  status;
    logic [nns_pkg::OUT_IDX_W-1:0] index;
    logic [nns_pkg::DIST_W-1:0]    distance;
  } match_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady_flow;
  int   mismatch_count;

  // Shadow copy of the point table and the results still owed by the block
  nns_pkg::point_t shadow_points [TABLE_DEPTH];
  int unsigned     shadow_count;
  match_t          pending_matches [$];

  nns_in_if  in_ch ();
  nns_out_if out_ch ();

  nearest_neighbor_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic nns_pkg::point_t make_point(logic [7:0] a, logic [7:0] b,
                                                 logic [7:0] c, logic [7:0] d);
    nns_pkg::point_t p;
    p.a = a;
    p.b = b;
    p.c = c;
    p.d = d;
    return p;
  endfunction

  // Sum of squared per-feature differences
  function automatic int unsigned squared_gap(nns_pkg::point_t p, nns_pkg::point_t q);
    logic [31:0] pv;
    logic [31:0] qv;
    int unsigned sum;
    int unsigned diff;
    pv  = p;
    qv  = q;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      if (pv[8*k +: 8] >= qv[8*k +: 8]) begin
        diff = pv[8*k +: 8] - qv[8*k +: 8];
      end else begin
        diff = qv[8*k +: 8] - pv[8*k +: 8];
      end
      sum += diff * diff;
    end
    return sum;
  endfunction

  // Predict the result of one accepted word and update the shadow table
  function automatic match_t predict_search(logic func, nns_pkg::point_t pt);
    match_t      r;
    int unsigned best;
    int unsigned best_idx;
    int unsigned d;
    r = '0;
    if (func == nns_pkg::FUNC_APPEND) begin
      if (shadow_count >= TABLE_DEPTH) begin
        r.status = nns_pkg::STAT_FULL;
      end else begin
        shadow_points[shadow_count] = pt;
        r.status = nns_pkg::STAT_OK;
        r.index  = shadow_count[nns_pkg::OUT_IDX_W-1:0];
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = nns_pkg::STAT_EMPTY;
    end else begin
      best     = squared_gap(pt, shadow_points[0]);
      best_idx = 0;
      // strict less-than keeps the lowest index on ties
      for (int unsigned i = 1; i < shadow_count; i++) begin
        d = squared_gap(pt, shadow_points[i]);
        if (d < best) begin
          best     = d;
          best_idx = i;
        end
      end
      r.status   = nns_pkg::STAT_OK;
      r.index    = best_idx[nns_pkg::OUT_IDX_W-1:0];
      r.distance = best[nns_pkg::DIST_W-1:0];
    end
    return r;
  endfunction

  // Random point: plain random, all-extreme bytes, near a stored point, or a copy
  function automatic nns_pkg::point_t pick_point();
    logic [31:0] v;
    logic [31:0] base;
    int unsigned kind;
    int          t;
    kind = $urandom_range(0, 99);
    v    = $urandom;
    if (kind >= 40 && kind < 55) begin
      for (int k = 0; k < 4; k++) begin
        v[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
    end else if (kind >= 55 && shadow_count != 0) begin
      base = shadow_points[$urandom_range(0, shadow_count - 1)];
      v    = base;
      if (kind < 85) begin
        for (int k = 0; k < 4; k++) begin
          t = int'(base[8*k +: 8]) + $urandom_range(0, 6) - 3;
          if (t < 0) t = 0;
          if (t > 255) t = 255;
          v[8*k +: 8] = t[7:0];
        end
      end
    end
    return nns_pkg::point_t'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Present one word at a falling edge, hold until accepted, then predict
  task automatic send_word(input logic func, input nns_pkg::point_t pt);
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.feature_a <= pt.a;
    in_ch.feature_b <= pt.b;
    in_ch.feature_c <= pt.c;
    in_ch.feature_d <= pt.d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_matches.push_back(predict_search(func, pt));
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d index=%0d dist=%0d",
                                  out_ch.status, out_ch.nearest_index,
                                  out_ch.best_distance));
      end else begin
        want = pending_matches.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.nearest_index !== want.index)
          report_mismatch($sformatf("nearest_index %0d, want %0d",
                                    out_ch.nearest_index, want.index));
        if (out_ch.best_distance !== want.distance)
          report_mismatch($sformatf("best_distance %0d, want %0d",
                                    out_ch.best_distance, want.distance));
      end
    end
  end

  // Queries before anything is stored
  task automatic test_empty_table();
    send_word(nns_pkg::FUNC_QUERY, make_point(8'h00, 8'h00, 8'h00, 8'h00));
    send_word(nns_pkg::FUNC_QUERY, make_point(8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // Largest distance, exact hits and near-midpoint queries
  task automatic test_extreme_points();
    send_word(nns_pkg::FUNC_APPEND, make_point(8'h00, 8'h00, 8'h00, 8'h00));
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'h00, 8'h00, 8'h00, 8'h00));
    send_word(nns_pkg::FUNC_APPEND, make_point(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'd128, 8'd128, 8'd128, 8'd128));
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'd127, 8'd127, 8'd127, 8'd127));
  endtask

  // Equal distances must report the lowest index
  task automatic test_tie_break();
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'h00, 8'h00, 8'hFF, 8'hFF));
    send_word(nns_pkg::FUNC_APPEND, make_point(8'h00, 8'hFF, 8'h00, 8'hFF));
    send_word(nns_pkg::FUNC_APPEND, make_point(8'hFF, 8'h00, 8'hFF, 8'h00));
    send_word(nns_pkg::FUNC_APPEND, make_point(8'h00, 8'h00, 8'h00, 8'h00));
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'h00, 8'h00, 8'h00, 8'h00));
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'hFF, 8'h00, 8'hFF, 8'h00));
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'd1, 8'd2, 8'd3, 8'd4));
  endtask

  // Mixed traffic while the table grows
  task automatic test_random_growth(input int count);
    for (int n = 0; n < count; n++) begin
      send_word(($urandom_range(0, 99) < 30) ? nns_pkg::FUNC_APPEND : nns_pkg::FUNC_QUERY,
                pick_point());
    end
  endtask

  // Fill the rest of the table, then appends are rejected
  task automatic test_fill_table();
    while (shadow_count < TABLE_DEPTH) begin
      send_word(nns_pkg::FUNC_APPEND, pick_point());
    end
    send_word(nns_pkg::FUNC_APPEND, make_point(8'h00, 8'h00, 8'h00, 8'h00));
    send_word(nns_pkg::FUNC_APPEND, make_point(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(nns_pkg::FUNC_APPEND, pick_point());
    send_word(nns_pkg::FUNC_QUERY,  make_point(8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // Full-table traffic, with a stretch where neither side idles
  task automatic test_random_full(input int count);
    for (int n = 0; n < count; n++) begin
      steady_flow = (n >= 200 && n < 400);
      send_word(($urandom_range(0, 99) < 35) ? nns_pkg::FUNC_APPEND : nns_pkg::FUNC_QUERY,
                pick_point());
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = nns_pkg::FUNC_APPEND;
    in_ch.feature_a = '0;
    in_ch.feature_b = '0;
    in_ch.feature_c = '0;
    in_ch.feature_d = '0;
    out_ch.ready    = 1'b0;
    steady_flow     = 1'b0;
    mismatch_count  = 0;
    shadow_count    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_extreme_points();
    test_tie_break();
    test_random_growth(700);
    test_fill_table();
    test_random_full(880);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(30_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
